// ===== rtl/bpc_pkg.sv =====
// Package for the blind position controller: widths, codes, state records
// and reset values. No dependencies; used by every module under rtl/.
package bpc_pkg;

   localparam int POSITION_BITS = 16;
   localparam int COUNT_BITS    = 16;
   localparam int TRAVEL_BITS   = 15;
   localparam int CMD_BITS      = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef logic signed [POSITION_BITS-1:0] pos_type;
   typedef logic [COUNT_BITS-1:0]           count_type;
   typedef logic [TRAVEL_BITS-1:0]          travel_type;

   localparam pos_type   POS_RESET      = pos_type'(10);
   localparam pos_type   TOP_RESET      = pos_type'(28);
   localparam pos_type   LOW_STOP_RESET = pos_type'(-32000);
   localparam count_type SETTLE_RESET   = count_type'(50);
   localparam count_type SAVE_RESET     = count_type'(30000);
   localparam travel_type TRAVEL_RESET  = travel_type'(28);

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SETTLE_MS     = 2'd0,
      CSR_SAVE_DELAY_MS = 2'd1,
      CSR_FORCE_TRAVEL  = 2'd2
   } csr_index_type;

   // user command codes
   typedef enum logic [CMD_BITS-1:0] {
      CMD_NONE       = 4'd0,
      CMD_STOP       = 4'd1,
      CMD_GO_TOP     = 4'd2,
      CMD_GO_MIDDLE  = 4'd3,
      CMD_GO_BOTTOM  = 4'd4,
      CMD_SET_TOP    = 4'd5,
      CMD_SET_MIDDLE = 4'd6,
      CMD_SET_BOTTOM = 4'd7,
      CMD_FORCE_UP   = 4'd8,
      CMD_FORCE_DOWN = 4'd9,
      CMD_TOGGLE     = 4'd10,
      CMD_INVERT     = 4'd11
   } command_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_STOP   = 3'd1,
      ACT_TOP    = 3'd2,
      ACT_MIDDLE = 3'd3,
      ACT_BOTTOM = 3'd4,
      ACT_FUP    = 3'd5,
      ACT_FDOWN  = 3'd6,
      ACT_TOGGLE = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_STOPPED = 2'd0,
      ST_RISING  = 2'd1,
      ST_FALLING = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      MO_STOPPED  = 3'd0,
      MO_STOPPING = 3'd1,
      MO_BRAKING  = 3'd2,
      MO_UP       = 3'd3,
      MO_DOWN     = 3'd4
   } motor_type;

   typedef enum logic [1:0] {
      PRE_NONE   = 2'd0,
      PRE_TOP    = 2'd1,
      PRE_MIDDLE = 2'd2,
      PRE_BOTTOM = 2'd3
   } preset_type;

   // motor sequencer state
   typedef struct packed {
      motor_type current;
      logic      dir_relay;
      logic      run_relay;
      count_type settle_count;
   } seq_state_type;

   // goal logic state
   typedef struct packed {
      action_type pending;
      status_type status;
      preset_type preset;
      pos_type    goal;
   } goal_state_type;

   // stored stop positions
   typedef struct packed {
      pos_type top;
      pos_type middle;
      pos_type bottom;
   } stops_type;

endpackage

// ===== rtl/bpc_motor_seq.sv =====
// Motor sequencer next-state logic: stop, brake, idle, set direction, run.
// Depends on bpc_pkg.
module bpc_motor_seq (
   input  bpc_pkg::seq_state_type seq_cur,
   input  bpc_pkg::motor_type     motor_target,
   input  logic                   up_direction,
   input  bpc_pkg::count_type     settle_ms,
   output bpc_pkg::seq_state_type seq_nxt
);
   import bpc_pkg::*;

   count_type count_inc;
   logic      settled;

   // advance the settle timer, saturating
   assign count_inc = (seq_cur.settle_count == '1) ? seq_cur.settle_count
                                                   : seq_cur.settle_count + 1'b1;
   assign settled   = (count_inc >= settle_ms);

   always_comb begin
      seq_nxt              = seq_cur;
      seq_nxt.settle_count = count_inc;
      if (motor_target != seq_cur.current) begin
         case (seq_cur.current)
            MO_UP, MO_DOWN: begin
               seq_nxt.run_relay    = 1'b0;
               seq_nxt.current      = MO_STOPPING;
               seq_nxt.settle_count = '0;
            end
            MO_STOPPING: begin
               // reverse the relay to brake
               if (settled) begin
                  seq_nxt.dir_relay    = ~seq_cur.dir_relay;
                  seq_nxt.current      = MO_BRAKING;
                  seq_nxt.settle_count = '0;
               end
            end
            MO_BRAKING: begin
               if (settled) begin
                  seq_nxt.dir_relay    = 1'b0;
                  seq_nxt.current      = MO_STOPPED;
                  seq_nxt.settle_count = '0;
               end
            end
            default: begin
               // idle: set direction first, then start on a later settle
               if (settled) begin
                  if (motor_target == MO_UP && seq_cur.dir_relay != up_direction) begin
                     seq_nxt.dir_relay = up_direction;
                  end else if (motor_target == MO_DOWN &&
                               seq_cur.dir_relay != ~up_direction) begin
                     seq_nxt.dir_relay = ~up_direction;
                  end else begin
                     if (motor_target != MO_STOPPED) begin
                        seq_nxt.current   = motor_target;
                        seq_nxt.run_relay = 1'b1;
                     end
                     seq_nxt.settle_count = '0;
                  end
               end
            end
         endcase
      end
   end

endmodule

// ===== rtl/bpc_blind_goal.sv =====
// Blind goal logic: resolve the pending action into a goal and motor target,
// and stop once the goal is reached. Depends on bpc_pkg.
module bpc_blind_goal (
   input  bpc_pkg::goal_state_type goal_state,
   input  bpc_pkg::pos_type        position,
   input  bpc_pkg::stops_type      stops,
   input  bpc_pkg::travel_type     force_travel,
   input  bpc_pkg::motor_type      motor_target,
   input  bpc_pkg::motor_type      motor_current,
   input  logic                    run_relay,
   output bpc_pkg::goal_state_type goal_next,
   output bpc_pkg::motor_type      target_next,
   output logic                    run_next
);
   import bpc_pkg::*;

   action_type act;
   pos_type    travel;
   pos_type    new_goal;
   logic       stop_return;

   assign travel = pos_type'({1'b0, force_travel});

   // turn a toggle into stop, top or middle
   always_comb begin
      act = goal_state.pending;
      if (goal_state.pending == ACT_TOGGLE) begin
         if (goal_state.status != ST_STOPPED) begin
            act = ACT_STOP;
         end else if (goal_state.preset == PRE_MIDDLE) begin
            act = ACT_TOP;
         end else begin
            act = ACT_MIDDLE;
         end
      end
   end

   always_comb begin
      goal_next   = goal_state;
      target_next = motor_target;
      run_next    = run_relay;
      stop_return = 1'b0;
      new_goal    = goal_state.goal;

      // act on the pending action
      if (act != ACT_NONE) begin
         goal_next.pending = ACT_NONE;
         if (act == ACT_STOP) begin
            target_next      = MO_STOPPED;
            goal_next.status = ST_STOPPED;
            stop_return      = 1'b1;
         end else begin
            case (act)
               ACT_TOP: begin
                  goal_next.preset = PRE_TOP;
                  new_goal         = stops.top;
               end
               ACT_MIDDLE: begin
                  goal_next.preset = PRE_MIDDLE;
                  new_goal         = stops.middle;
               end
               ACT_BOTTOM: begin
                  goal_next.preset = PRE_BOTTOM;
                  new_goal         = stops.bottom;
               end
               ACT_FUP:   new_goal = position + travel;
               ACT_FDOWN: new_goal = position - travel;
               default:   new_goal = goal_state.goal;
            endcase
            goal_next.goal = new_goal;
            if (position < new_goal) begin
               goal_next.status = ST_RISING;
               target_next      = MO_UP;
            end else if (position > new_goal) begin
               goal_next.status = ST_FALLING;
               target_next      = MO_DOWN;
            end else begin
               goal_next.status = ST_STOPPED;
               target_next      = MO_STOPPED;
            end
         end
      end

      // track the goal once the motor has caught up
      if (!stop_return && target_next == motor_current) begin
         case (goal_next.status)
            ST_STOPPED: run_next = 1'b0;
            ST_FALLING: begin
               if (position <= goal_next.goal) begin
                  target_next      = MO_STOPPED;
                  goal_next.status = ST_STOPPED;
               end
            end
            ST_RISING: begin
               if (position >= goal_next.goal) begin
                  target_next      = MO_STOPPED;
                  goal_next.status = ST_STOPPED;
               end
            end
            default: goal_next.status = goal_next.status;
         endcase
      end
   end

endmodule

// ===== rtl/motorized_blind_position_controller.sv =====
// Motorized blind position controller, top level: state and configuration
// registers, tick update and result register. Depends on bpc_pkg,
// bpc_motor_seq and bpc_blind_goal.
//
// Usage:
//   Each req_ transaction is one millisecond tick with an optional rotation
//   pulse and a command code. Every tick produces exactly one rsp_
//   transaction with the relay drives, motion status, position and a save
//   request flag.
//   The result of a tick is registered at the edge that accepts it. Throughput is
//   one tick per cycle while the receiver takes each result; the whole tick
//   update is a single combinational pass from the state registers into
//   the state and result registers.
//   req_ready is high whenever the result register is empty or is being
//   taken in the same cycle, so a stalled receiver holds the result and
//   back-pressures the input after one transaction.
//   Reset (synchronous, active high) restores the configuration defaults
//   (settle 50, save delay 30000, force travel 28), position 10, top stop
//   28, middle and bottom stops -32000, and empties the result register.
//   csr_ writes take effect at the edge where csr_we is high and should be
//   issued only while the block is idle.
module motorized_blind_position_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_rotation_pulse,
   input  logic [bpc_pkg::CMD_BITS-1:0]       req_command,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_motor_on,
   output logic                               rsp_motor_dir,
   output logic [1:0]                         rsp_blind_status,
   output logic signed [15:0]                 rsp_position_out,
   output logic                               rsp_save_request,
   input  logic                               csr_we,
   input  logic [bpc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bpc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bpc_pkg::*;

   // configuration
   count_type  settle_ms_ff, save_delay_ff;
   travel_type force_travel_ff;

   // tick state
   pos_type         position_ff, position_in;
   stops_type       stops_ff, stops_in;
   logic            up_dir_ff, up_dir_in;
   count_type       still_ff, still_in;
   logic            dirty_ff, dirty_in;
   motor_type       target_ff, target_in;
   seq_state_type   motor_ff, motor_mid;
   goal_state_type  goal_ff, goal_mid, goal_in;
   motor_type       target_mid;
   logic            run_mid;

   // result register
   logic            rsp_valid_ff;
   logic            out_on_ff, out_dir_ff, out_save_ff;
   status_type      out_status_ff;
   pos_type         out_pos_ff;

   logic            accept;
   logic            save_still, save_in;
   seq_state_type   motor_in;
   command_type     cmd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = command_type'(req_command);

   // count rotation pulses and the still timer
   always_comb begin
      position_in = position_ff;
      still_in    = still_ff;
      dirty_in    = dirty_ff;
      if (req_rotation_pulse) begin
         position_in = (motor_ff.dir_relay == up_dir_ff) ? position_ff + 1'b1
                                                          : position_ff - 1'b1;
         still_in    = '0;
         dirty_in    = 1'b1;
      end else if (still_ff != '1) begin
         still_in = still_ff + 1'b1;
      end
      save_still = dirty_in && (still_in >= save_delay_ff);
   end

   bpc_motor_seq u_motor_seq (
      .seq_cur      (motor_ff),
      .motor_target (target_ff),
      .up_direction (up_dir_ff),
      .settle_ms    (settle_ms_ff),
      .seq_nxt      (motor_mid)
   );

   bpc_blind_goal u_blind_goal (
      .goal_state    (goal_ff),
      .position      (position_in),
      .stops         (stops_ff),
      .force_travel  (force_travel_ff),
      .motor_target  (target_ff),
      .motor_current (motor_mid.current),
      .run_relay     (motor_mid.run_relay),
      .goal_next     (goal_mid),
      .target_next   (target_mid),
      .run_next      (run_mid)
   );

   // decode the command; goal commands become pending for the next tick
   always_comb begin
      motor_in           = motor_mid;
      motor_in.run_relay = run_mid;
      target_in          = target_mid;
      goal_in            = goal_mid;
      stops_in           = stops_ff;
      up_dir_in          = up_dir_ff;
      save_in            = save_still;
      case (cmd)
         CMD_STOP:       goal_in.pending = ACT_STOP;
         CMD_GO_TOP:     goal_in.pending = ACT_TOP;
         CMD_GO_MIDDLE:  goal_in.pending = ACT_MIDDLE;
         CMD_GO_BOTTOM:  goal_in.pending = ACT_BOTTOM;
         CMD_FORCE_UP:   goal_in.pending = ACT_FUP;
         CMD_FORCE_DOWN: goal_in.pending = ACT_FDOWN;
         CMD_TOGGLE:     goal_in.pending = ACT_TOGGLE;
         CMD_SET_TOP: begin
            stops_in.top = position_in;
            save_in      = 1'b1;
         end
         CMD_SET_MIDDLE: begin
            stops_in.middle = position_in;
            save_in         = 1'b1;
         end
         CMD_SET_BOTTOM: begin
            stops_in.bottom = position_in;
            save_in         = 1'b1;
         end
         CMD_INVERT: begin
            up_dir_in = ~up_dir_ff;
            save_in   = 1'b1;
         end
         default: save_in = save_still;
      endcase
   end

   // hold configuration and tick state; advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ms_ff    <= SETTLE_RESET;
         save_delay_ff   <= SAVE_RESET;
         force_travel_ff <= TRAVEL_RESET;
         position_ff     <= POS_RESET;
         stops_ff        <= '{top: TOP_RESET, middle: LOW_STOP_RESET,
                              bottom: LOW_STOP_RESET};
         up_dir_ff       <= 1'b0;
         still_ff        <= '0;
         dirty_ff        <= 1'b0;
         target_ff       <= MO_STOPPED;
         motor_ff        <= '{current: MO_STOPPED, dir_relay: 1'b0, run_relay: 1'b0,
                              settle_count: '0};
         goal_ff         <= '{pending: ACT_NONE, status: ST_STOPPED, preset: PRE_NONE,
                              goal: TOP_RESET};
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SETTLE_MS:     settle_ms_ff    <= csr_wdata;
               CSR_SAVE_DELAY_MS: save_delay_ff   <= csr_wdata;
               CSR_FORCE_TRAVEL:  force_travel_ff <= csr_wdata[TRAVEL_BITS-1:0];
               default:           settle_ms_ff    <= settle_ms_ff;
            endcase
         end
         if (accept) begin
            position_ff  <= position_in;
            stops_ff     <= stops_in;
            up_dir_ff    <= up_dir_in;
            still_ff     <= still_in;
            dirty_ff     <= dirty_in && !save_still;
            target_ff    <= target_in;
            motor_ff     <= motor_in;
            goal_ff      <= goal_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // load the result register
   always_ff @(posedge clock) begin
      if (accept) begin
         out_on_ff     <= motor_in.run_relay;
         out_dir_ff    <= motor_in.dir_relay;
         out_status_ff <= goal_in.status;
         out_pos_ff    <= position_in;
         out_save_ff   <= save_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor_on     = out_on_ff;
   assign rsp_motor_dir    = out_dir_ff;
   assign rsp_blind_status = out_status_ff;
   assign rsp_position_out = out_pos_ff;
   assign rsp_save_request = out_save_ff;

   // the run relay is only on while the motor is running
   a_run_only_when_moving: assert property (@(posedge clock) disable iff (reset)
      motor_ff.run_relay |-> (motor_ff.current == MO_UP || motor_ff.current == MO_DOWN))
      else $error("run relay on outside a running motor state");

   // braking never drives the run relay
   a_no_run_while_braking: assert property (@(posedge clock) disable iff (reset)
      (motor_ff.current == MO_BRAKING || motor_ff.current == MO_STOPPING)
      |-> !motor_ff.run_relay)
      else $error("run relay on while stopping or braking");

   // a pulse always moves the position by one
   a_pulse_moves_position: assert property (@(posedge clock) disable iff (reset)
      (accept && req_rotation_pulse) |=> (position_ff != $past(position_ff)))
      else $error("rotation pulse did not move the position");

   // every accepted tick produces a result
   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted tick produced no result");

   // a save request from the still timer clears the dirty mark
   a_save_clears_dirty: assert property (@(posedge clock) disable iff (reset)
      (accept && save_still) |=> !dirty_ff)
      else $error("position still dirty after save request");

endmodule

// ===== test/testbench.sv =====
// Testbench for motorized_blind_position_controller: sends millisecond ticks
// over valid/ready, predicts each tick result and checks it field by field.
// Depends on bpc_pkg and the controller RTL.
module testbench;
   import bpc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = CMD_BITS'(CMD_INVERT + 1);
   localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = '1;

   // expected contents of one rsp_ transaction
   typedef struct packed {
      logic       motor_on;
      logic       motor_dir;
      logic [1:0] status;
      pos_type    position;
      logic       save;
   } tick_result_type;

   // one configuration setting and the number of random ticks run under it
   typedef struct packed {
      count_type   settle;
      count_type   save_delay;
      travel_type  travel;
      int unsigned ticks;
   } phase_type;

   localparam phase_type PHASES [5] = '{
      '{16'd0,     16'd0,     15'd0,     100},
      '{16'd2,     16'd5,     15'd3,     200},
      '{16'd1,     16'd20,    15'd32767, 150},
      '{16'd65535, 16'd65535, 15'd1,     50},
      '{16'd3,     16'd12,    15'd9,     220}
   };

   // {rotation_pulse, command} for the directed opening
   localparam logic [CMD_BITS:0] DIRECTED [21] = '{
      {1'b1, CMD_NONE},       {1'b1, CMD_SET_MIDDLE}, {1'b0, CMD_SET_BOTTOM},
      {1'b0, CMD_GO_TOP},     {1'b0, CMD_NONE},       {1'b1, CMD_STOP},
      {1'b0, CMD_GO_MIDDLE},  {1'b0, CMD_NONE},       {1'b0, CMD_GO_BOTTOM},
      {1'b0, CMD_NONE},       {1'b1, CMD_FORCE_UP},   {1'b0, CMD_NONE},
      {1'b0, CMD_FORCE_DOWN}, {1'b0, CMD_NONE},       {1'b0, CMD_TOGGLE},
      {1'b0, CMD_NONE},       {1'b0, CMD_TOGGLE},     {1'b0, CMD_INVERT},
      {1'b1, CMD_INVERT},     {1'b0, CMD_SET_TOP},    {1'b1, CMD_NONE}
   };

   // Tracks the blind controller state and the queue of expected tick results
   class blind_tracker;
      tick_result_type expected_ticks[$];
      int              mismatches;
      int              results_seen;
      count_type       settle_ms, save_delay_ms;
      travel_type      force_travel;
      pos_type         position, goal, upper_stop, center_stop, lower_stop;
      logic            up_dir, dir_relay, run_relay, dirty;
      action_type      pending;
      status_type      status;
      preset_type      preset;
      motor_type       motor_now, motor_goal;
      count_type       settle_count, still_count;

      function new();
         mismatches    = 0;
         results_seen  = 0;
         settle_ms     = SETTLE_RESET;
         save_delay_ms = SAVE_RESET;
         force_travel  = TRAVEL_RESET;
         position      = POS_RESET;
         goal          = TOP_RESET;
         upper_stop    = TOP_RESET;
         center_stop   = LOW_STOP_RESET;
         lower_stop    = LOW_STOP_RESET;
         up_dir        = 1'b0;
         dir_relay     = 1'b0;
         run_relay     = 1'b0;
         dirty         = 1'b0;
         pending       = ACT_NONE;
         status        = ST_STOPPED;
         preset        = PRE_NONE;
         motor_now     = MO_STOPPED;
         motor_goal    = MO_STOPPED;
         settle_count  = '0;
         still_count   = '0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_SETTLE_MS:     settle_ms = value;
            CSR_SAVE_DELAY_MS: save_delay_ms = value;
            CSR_FORCE_TRAVEL:  force_travel = value[TRAVEL_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Advance the state by one accepted tick and queue its result
      function void note_tick(logic pulse, logic [CMD_BITS-1:0] cmd);
         tick_result_type want;
         logic save;
         logic halted;
         save = 1'b0;
         halted = 1'b0;

         // count the shaft pulse in the direction the relay points
         if (pulse) begin
            if (dir_relay == up_dir)
               position = position + pos_type'(1);
            else
               position = position - pos_type'(1);
            still_count = '0;
            dirty = 1'b1;
         end else if (still_count != '1) begin
            still_count = still_count + 1'b1;
         end

         // request a save once the position has rested long enough
         if (dirty && still_count >= save_delay_ms) begin
            save = 1'b1;
            dirty = 1'b0;
         end

         // motor sequencer: stop, brake, idle, set direction, run
         if (settle_count != '1)
            settle_count = settle_count + 1'b1;
         if (motor_goal != motor_now) begin
            case (motor_now)
               MO_UP, MO_DOWN: begin
                  run_relay = 1'b0;
                  motor_now = MO_STOPPING;
                  settle_count = '0;
               end
               MO_STOPPING: if (settle_count >= settle_ms) begin
                  dir_relay = ~dir_relay;
                  motor_now = MO_BRAKING;
                  settle_count = '0;
               end
               MO_BRAKING: if (settle_count >= settle_ms) begin
                  dir_relay = 1'b0;
                  motor_now = MO_STOPPED;
                  settle_count = '0;
               end
               default: if (settle_count >= settle_ms) begin
                  if (motor_goal == MO_UP && dir_relay != up_dir) begin
                     dir_relay = up_dir;
                  end else if (motor_goal == MO_DOWN && dir_relay == up_dir) begin
                     dir_relay = ~up_dir;
                  end else begin
                     if (motor_goal != MO_STOPPED) begin
                        motor_now = motor_goal;
                        run_relay = 1'b1;
                     end
                     settle_count = '0;
                  end
               end
            endcase
         end

         // resolve the one-button toggle from the current motion
         if (pending == ACT_TOGGLE) begin
            if (status != ST_STOPPED)
               pending = ACT_STOP;
            else if (preset == PRE_MIDDLE)
               pending = ACT_TOP;
            else
               pending = ACT_MIDDLE;
         end

         // act on the command left pending by the previous tick
         if (pending == ACT_STOP) begin
            motor_goal = MO_STOPPED;
            status = ST_STOPPED;
            pending = ACT_NONE;
            halted = 1'b1;
         end else if (pending != ACT_NONE) begin
            case (pending)
               ACT_TOP: begin
                  preset = PRE_TOP;
                  goal = upper_stop;
               end
               ACT_MIDDLE: begin
                  preset = PRE_MIDDLE;
                  goal = center_stop;
               end
               ACT_BOTTOM: begin
                  preset = PRE_BOTTOM;
                  goal = lower_stop;
               end
               ACT_FUP:   goal = position + pos_type'({1'b0, force_travel});
               ACT_FDOWN: goal = position - pos_type'({1'b0, force_travel});
               default: ;
            endcase
            if (position < goal) begin
               status = ST_RISING;
               motor_goal = MO_UP;
            end else if (position > goal) begin
               status = ST_FALLING;
               motor_goal = MO_DOWN;
            end else begin
               status = ST_STOPPED;
               motor_goal = MO_STOPPED;
            end
            pending = ACT_NONE;
         end

         // end of travel, and drop a run relay left on while stopped
         if (!halted && motor_goal == motor_now) begin
            if (status == ST_STOPPED) begin
               run_relay = 1'b0;
            end else if (status == ST_FALLING && position <= goal) begin
               motor_goal = MO_STOPPED;
               status = ST_STOPPED;
            end else if (status == ST_RISING && position >= goal) begin
               motor_goal = MO_STOPPED;
               status = ST_STOPPED;
            end
         end

         // decode the new command; goal commands wait for the next tick
         case (cmd)
            CMD_STOP:       pending = ACT_STOP;
            CMD_GO_TOP:     pending = ACT_TOP;
            CMD_GO_MIDDLE:  pending = ACT_MIDDLE;
            CMD_GO_BOTTOM:  pending = ACT_BOTTOM;
            CMD_FORCE_UP:   pending = ACT_FUP;
            CMD_FORCE_DOWN: pending = ACT_FDOWN;
            CMD_TOGGLE:     pending = ACT_TOGGLE;
            CMD_SET_TOP: begin
               upper_stop = position;
               save = 1'b1;
            end
            CMD_SET_MIDDLE: begin
               center_stop = position;
               save = 1'b1;
            end
            CMD_SET_BOTTOM: begin
               lower_stop = position;
               save = 1'b1;
            end
            CMD_INVERT: begin
               up_dir = ~up_dir;
               save = 1'b1;
            end
            default: ;
         endcase

         want.motor_on  = run_relay;
         want.motor_dir = dir_relay;
         want.status    = status;
         want.position  = position;
         want.save      = save;
         expected_ticks.push_back(want);
      endfunction

      task report(string what);
         $display("tick result %0d: %s", results_seen, what);
         mismatches++;
      endtask

      // Compare one rsp_ transaction with the oldest expected result
      task check_result(tick_result_type got);
         tick_result_type want;
         if (expected_ticks.size() == 0) begin
            report($sformatf("unexpected result, position %0d", got.position));
         end else begin
            want = expected_ticks.pop_front();
            if (got.motor_on !== want.motor_on)
               report($sformatf("motor_on %b, expected %b", got.motor_on, want.motor_on));
            if (got.motor_dir !== want.motor_dir)
               report($sformatf("motor_dir %b, expected %b", got.motor_dir, want.motor_dir));
            if (got.status !== want.status)
               report($sformatf("blind_status %0d, expected %0d", got.status, want.status));
            if (got.position !== want.position)
               report($sformatf("position_out %0d, expected %0d",
                                got.position, want.position));
            if (got.save !== want.save)
               report($sformatf("save_request %b, expected %b", got.save, want.save));
         end
         results_seen++;
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_rotation_pulse;
   logic [CMD_BITS-1:0]       req_command;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_motor_on;
   logic                      rsp_motor_dir;
   logic [1:0]                rsp_blind_status;
   logic signed [15:0]        rsp_position_out;
   logic                      rsp_save_request;
   logic                      csr_we;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int           send_idle_pct = 36;
   int           recv_idle_pct = 74;
   int           ticks_sent = 0;
   int           cycles = 0;
   blind_tracker tracker = new();

   motorized_blind_position_controller dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rotation_pulse (req_rotation_pulse),
      .req_command        (req_command),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_motor_on       (rsp_motor_on),
      .rsp_motor_dir      (rsp_motor_dir),
      .rsp_blind_status   (rsp_blind_status),
      .rsp_position_out   (rsp_position_out),
      .rsp_save_request   (rsp_save_request),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // abort a run that hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[motorized_blind_position_controller] ERROR");
         $finish;
      end
   end

   // take results with random stalls and check each one
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready)
            tracker.check_result('{rsp_motor_on, rsp_motor_dir, rsp_blind_status,
                                   rsp_position_out, rsp_save_request});
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one tick after random idle cycles and hold it until accepted
   task automatic send_tick(input logic pulse, input logic [CMD_BITS-1:0] cmd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rotation_pulse <= pulse;
      req_command <= cmd;
      do @(posedge clock); while (!req_ready);
      tracker.note_tick(pulse, cmd);
      ticks_sent++;
      // swap the idle pattern, then run without idling
      if (ticks_sent == 250) begin
         send_idle_pct = 74;
         recv_idle_pct = 36;
      end else if (ticks_sent == 500) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Hold off the sender until every expected result has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.expected_ticks.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   initial begin
      int                  roll;
      logic                pulse;
      logic [CMD_BITS-1:0] cmd;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rotation_pulse <= 1'b0;
      req_command <= CMD_NONE;
      csr_we <= 1'b0;
      csr_index <= CSR_SETTLE_MS;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening at the reset configuration, spare codes included
      foreach (DIRECTED[i])
         send_tick(DIRECTED[i][CMD_BITS], DIRECTED[i][CMD_BITS-1:0]);
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         send_tick(c[0], CMD_BITS'(c));

      // random ticks under each setting; pulses mostly while the motor runs
      foreach (PHASES[p]) begin
         wait_drained();
         write_register(CSR_SETTLE_MS, PHASES[p].settle);
         write_register(CSR_SAVE_DELAY_MS, PHASES[p].save_delay);
         write_register(CSR_FORCE_TRAVEL, CSR_DATA_BITS'(PHASES[p].travel));
         csr_we <= 1'b0;
         for (int n = 0; n < PHASES[p].ticks; n++) begin
            if (n == PHASES[p].ticks / 2)
               wait_drained();
            roll = $urandom_range(99);
            if (roll < 6)
               cmd = CMD_BITS'($urandom_range(CMD_STOP, CMD_INVERT));
            else if (roll < 7)
               cmd = CMD_BITS'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            else
               cmd = CMD_NONE;
            if (tracker.run_relay)
               pulse = ($urandom_range(9) < 8);
            else
               pulse = ($urandom_range(9) == 0);
            send_tick(pulse, cmd);
         end
      end

      wait_drained();
      if (tracker.mismatches == 0)
         $display("[motorized_blind_position_controller] OK");
      else
         $display("[motorized_blind_position_controller] ERROR");
      $finish;
   end

endmodule
